[rtl/assert_macros.svh]
// Assertion macros, included by incremental_pid_controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ipid_pkg.sv]
// Package: widths, register indexes and FSM states of the incremental PID controller.
`timescale 1ns / 1ps
package ipid_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int COEF_W     = 32;
    localparam int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_KR          = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KI_RATIO    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_KD_RATIO    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT = CFG_IDX_W'(3);

    localparam logic signed [COEF_W-1:0] UPPER_RST = COEF_W'(27 * (2 ** FRAC_BITS));

    // Product terms saturate at +-2^TLIM_SH, held in TERM_W signed bits.
    localparam int TLIM_SH = 60;
    localparam int TERM_W  = TLIM_SH + 2;

    // e - 2*e1 + e2
    localparam int D2_W    = DATA_WIDTH + 2;
    localparam int TRM_RAW = D2_W + COEF_W - FRAC_BITS;
    localparam int TRM_W   = (TRM_RAW < TERM_W) ? TRM_RAW : TERM_W;
    localparam int SUM_W   = TRM_W + 2;
    localparam int MUL_A_W = SUM_W;
    localparam int U_W     = TERM_W + 1;
    localparam int CNT_W   = $clog2(COEF_W + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_I,
        S_MUL_I,
        S_MUL_D,
        S_START_P,
        S_MUL_P,
        S_CLAMP
    } ipid_state_t;

endpackage

[rtl/ipid_sermul.sv]
// Serial-parallel multiplier: signed operand times unsigned coefficient, one coefficient
// bit per cycle, floor shift by FRAC_BITS and saturation of the term.
`timescale 1ns / 1ps
module ipid_sermul
    import ipid_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic [COEF_W-1:0]         k,
    output logic                      done,
    output logic signed [TERM_W-1:0]  result
);

    localparam int LOW_W = COEF_W - FRAC_BITS;
    localparam int P_W   = MUL_A_W + 1 + LOW_W;
    localparam int X_W   = (P_W > TERM_W) ? P_W : TERM_W;
    localparam logic signed [X_W-1:0] TLIM_POS = X_W'({1'b1, {TLIM_SH{1'b0}}});
    localparam logic signed [X_W-1:0] TLIM_NEG = -TLIM_POS;

    logic signed [MUL_A_W-1:0] a_reg;
    logic [COEF_W-1:0]         k_reg;
    logic signed [MUL_A_W:0]   acc_reg;
    logic [LOW_W-1:0]          low_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      done_reg;

    logic signed [MUL_A_W:0]   addend;
    logic signed [MUL_A_W:0]   step_sum;
    logic signed [P_W-1:0]     prod;
    logic signed [X_W-1:0]     prod_x;

    assign addend   = k_reg[0] ? (MUL_A_W + 1)'(a_reg) : '0;
    assign step_sum = acc_reg + addend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(COEF_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            k_reg   <= k;
            acc_reg <= '0;
            low_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            k_reg   <= k_reg >> 1;
            acc_reg <= step_sum >>> 1;
            low_reg <= {step_sum[0], low_reg[LOW_W-1:1]};
        end
    end

    assign prod   = {acc_reg, low_reg};
    assign prod_x = X_W'(prod);

    always_comb
    begin
        if (prod_x > TLIM_POS)
        begin
            result = TLIM_POS[TERM_W-1:0];
        end
        else if (prod_x < TLIM_NEG)
        begin
            result = TLIM_NEG[TERM_W-1:0];
        end
        else
        begin
            result = prod_x[TERM_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

[rtl/incremental_pid_controller.sv]
// Each item runs the serial multiplier, which takes one coefficient bit per cycle, three times
// (integral, derivative, gain); a new input is taken only after the previous item has finished.
// A new input is taken while the previous result still waits in the output register.
// Reset (rst_n, async, active low): gains zero, upper limit 27.0, history zero, no result.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module incremental_pid_controller
    import ipid_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [TDATA_W-1:0]   s_axis_tdata,   // error_value
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,   // drive_value
    output logic [0:0]           m_axis_tuser,   // limited
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data
);

    localparam logic signed [U_W-1:0] DMAX_U = U_W'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam logic signed [U_W-1:0] DMIN_U = -DMAX_U - U_W'(1);

    ipid_state_t state_reg;
    ipid_state_t state_next;

    logic [COEF_W-1:0]            kr_reg;
    logic [COEF_W-1:0]            ki_reg;
    logic [COEF_W-1:0]            kd_reg;
    logic signed [COEF_W-1:0]     upper_reg;

    logic signed [DATA_WIDTH-1:0] last_error_reg;
    logic signed [DATA_WIDTH-1:0] older_error_reg;
    logic signed [DATA_WIDTH-1:0] last_drive_reg;

    logic signed [DATA_WIDTH-1:0] e_reg;
    logic signed [SUM_W-1:0]      sum_reg;
    logic signed [U_W-1:0]        u_reg;
    logic [DATA_WIDTH-1:0]        m_data_reg;
    logic                         m_lim_reg;
    logic                         m_valid_reg;

    logic                         in_fire;
    logic                         cfg_fire;
    logic                         cfg_known;
    logic                         out_load;
    logic                         mul_start;
    logic                         mul_done;
    logic signed [MUL_A_W-1:0]    mul_a;
    logic [COEF_W-1:0]            mul_k;
    logic signed [TERM_W-1:0]     mul_res;
    logic signed [TRM_W-1:0]      term_s;
    logic signed [SUM_W-1:0]      d1;
    logic signed [MUL_A_W-1:0]    d2;
    logic signed [U_W-1:0]        up_ext;
    logic signed [U_W-1:0]        clamp_val;
    logic                         clamp_lim;

    ipid_sermul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .k      (mul_k),
        .done   (mul_done),
        .result (mul_res)
    );

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_known = (cfg_index == CFG_KR) || (cfg_index == CFG_KI_RATIO) ||
                       (cfg_index == CFG_KD_RATIO) || (cfg_index == CFG_UPPER_LIMIT);

    assign d1     = SUM_W'(e_reg) - SUM_W'(last_error_reg);
    assign d2     = MUL_A_W'(e_reg) - (MUL_A_W'(last_error_reg) <<< 1)
                    + MUL_A_W'(older_error_reg);
    assign term_s = mul_res[TRM_W-1:0];
    assign up_ext = U_W'(upper_reg);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        mul_start     = 1'b0;
        mul_a         = '0;
        mul_k         = '0;
        out_load      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = S_LOAD_I;
                end
            end
            S_LOAD_I:
            begin
                mul_start  = 1'b1;
                mul_a      = MUL_A_W'(e_reg);
                mul_k      = ki_reg;
                state_next = S_MUL_I;
            end
            S_MUL_I:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = d2;
                    mul_k      = kd_reg;
                    state_next = S_MUL_D;
                end
            end
            S_MUL_D:
            begin
                if (mul_done)
                begin
                    state_next = S_START_P;
                end
            end
            S_START_P:
            begin
                mul_start  = 1'b1;
                mul_a      = sum_reg;
                mul_k      = kr_reg;
                state_next = S_MUL_P;
            end
            S_MUL_P:
            begin
                if (mul_done)
                begin
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // upper clamp, then the output word range
    always_comb
    begin
        clamp_val = u_reg;
        clamp_lim = 1'b0;
        if (clamp_val > up_ext)
        begin
            clamp_val = up_ext;
            clamp_lim = 1'b1;
        end
        if (clamp_val > DMAX_U)
        begin
            clamp_val = DMAX_U;
            clamp_lim = 1'b1;
        end
        if (clamp_val < DMIN_U)
        begin
            clamp_val = DMIN_U;
            clamp_lim = 1'b1;
        end
    end

    // config registers and controller history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kr_reg          <= '0;
            ki_reg          <= '0;
            kd_reg          <= '0;
            upper_reg       <= UPPER_RST;
            last_error_reg  <= '0;
            older_error_reg <= '0;
            last_drive_reg  <= '0;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                CFG_KR:          kr_reg    <= cfg_data;
                CFG_KI_RATIO:    ki_reg    <= cfg_data;
                CFG_KD_RATIO:    kd_reg    <= cfg_data;
                CFG_UPPER_LIMIT: upper_reg <= cfg_data;
                default:         ;
            endcase
            if (cfg_known)
            begin
                last_error_reg  <= '0;
                older_error_reg <= '0;
                last_drive_reg  <= '0;
            end
        end
        else if (out_load)
        begin
            last_drive_reg  <= clamp_val[DATA_WIDTH-1:0];
            older_error_reg <= last_error_reg;
            last_error_reg  <= e_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            e_reg <= s_axis_tdata[DATA_WIDTH-1:0];
        end
        if (state_reg == S_LOAD_I)
        begin
            sum_reg <= d1;
        end
        else if (state_reg == S_MUL_D && mul_done)
        begin
            sum_reg <= sum_reg + SUM_W'(term_s);
        end
        else if (state_reg == S_MUL_I && mul_done)
        begin
            sum_reg <= sum_reg + SUM_W'(term_s);
        end
        if (state_reg == S_MUL_P && mul_done)
        begin
            u_reg <= U_W'(last_drive_reg) + U_W'(mul_res);
        end
        if (out_load)
        begin
            m_data_reg <= clamp_val[DATA_WIDTH-1:0];
            m_lim_reg  <= clamp_lim;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = TDATA_W'(m_data_reg);
    assign m_axis_tuser[0] = m_lim_reg;

    `ASSERT_IMPLIES(a_mul_done_state, clk, rst_n, mul_done, (state_reg == S_MUL_I || state_reg == S_MUL_D || state_reg == S_MUL_P), "multiplier finished outside a multiply state")
    `ASSERT_NEXT(a_accept_starts, clk, rst_n, in_fire, (state_reg == S_LOAD_I), "accepted transaction did not start the sequence")
    `ASSERT_NEXT(a_history_matches, clk, rst_n, out_load, (m_axis_tvalid && (last_drive_reg == $signed(m_data_reg)) && (last_error_reg == e_reg)), "history does not follow the delivered result")

endmodule
